### rtl/angle_rate_quadratic_estimator_top_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the angle rate quadratic estimator.
// ----------------------------------------------------------------------------
`ifndef ANGLE_RATE_QUADRATIC_ESTIMATOR_TOP_ASSERT_SVH
`define ANGLE_RATE_QUADRATIC_ESTIMATOR_TOP_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define ARQE_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define ARQE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

### rtl/arqe_pkg.sv
// ----------------------------------------------------------------------------
// arqe_pkg
// Types, constants and helpers shared by the estimator and its divider.
// ----------------------------------------------------------------------------
package arqe_pkg;

  // Number of sample points; the point field is six bits wide.
  localparam int POINTS = 64;
  localparam int PT_AW  = (POINTS > 1) ? $clog2(POINTS) : 1;

  // Divider numerator width: a 62-bit magnitude times a 32-bit magnitude.
  localparam int DIV_NUM_W = 94;
  // Quotient bits produced per divider step, and steps per division.
  localparam int DIV_RADIX = 4;
  localparam int DIV_STEPS = 64 / DIV_RADIX;

  localparam logic [63:0] QCLAMP = 64'h1000_0000_0000_0000;
  localparam logic signed [63:0] MAX48 = 64'sh0000_7FFF_FFFF_FFFF;
  localparam logic signed [63:0] MIN48 = -64'sh0000_8000_0000_0000;

  // History row of one point: slot 2 is the newest pair.
  typedef struct packed {
    logic [31:0] a0;
    logic [31:0] t0;
    logic [31:0] a1;
    logic [31:0] t1;
    logic [31:0] a2;
    logic [31:0] t2;
  } row_t;

  // Request to the shared divider.
  typedef struct packed {
    logic                 start;
    logic                 neg;
    logic [DIV_NUM_W-1:0] num;
    logic [31:0]          den;
  } div_req_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_EVAL,
    ST_DIV,
    ST_DIVW,
    ST_MUL_LO,
    ST_MUL_HI,
    ST_MUL_SUM,
    ST_FIN,
    ST_OUT
  } st_t;

  typedef enum logic [1:0] {
    OP_D01,
    OP_D12,
    OP_RATE,
    OP_ACCEL
  } op_t;

  localparam logic ACT_PREDICT = 1'b0;
  localparam logic ACT_UPDATE  = 1'b1;

  // Magnitude of a 33-bit signed difference.
  function automatic logic [31:0] abs33(input logic signed [32:0] v);
    logic signed [32:0] n;
    n = -v;
    return v[32] ? n[31:0] : v[31:0];
  endfunction

  // Magnitude of a 64-bit signed value known to stay within 2^61.
  function automatic logic [61:0] abs64(input logic signed [63:0] v);
    logic signed [63:0] n;
    n = -v;
    return v[63] ? n[61:0] : v[61:0];
  endfunction

  // Saturate to 48 bits signed.
  function automatic logic signed [47:0] sat48(input logic signed [63:0] v);
    logic signed [63:0] r;
    if (v > MAX48) begin
      r = MAX48;
    end else if (v < MIN48) begin
      r = MIN48;
    end else begin
      r = v;
    end
    return r[47:0];
  endfunction

endpackage

### rtl/angle_rate_quadratic_estimator_top.sv
// ----------------------------------------------------------------------------
// Angle rate quadratic estimator
// Fits a quadratic through three stored (angle, time) pairs of a point and
// returns its first and second time derivatives at the newest time.
// ----------------------------------------------------------------------------
//  Channel  | Handshake              | Payload
//  ---------+------------------------+-------------------------------------
//  input    | start / busy           | in_action, in_point, in_angle, in_time_now
//  result   | out_valid (strobe)     | out_rate, out_accel, out_valid_res
//  config   | cfg_valid / cfg_ready  | cfg_data (unsteady_enable)
//
// An update item, or a predict item without an estimate, goes from the
// evaluate state straight to the output state and strobes its result there.
// A predict item with an estimate runs four divisions (each a start, 16
// divider iterations, rounding and handoff), with the split multiply (low,
// high and sum states) before the third, then the finish and output states.
// One item is in flight at a time; busy is high until the result strobe and
// the enable register is only written while idle. History sits in one
// row-wide memory; per-row valid bits make unwritten rows read as zero.
// The receiver cannot stall; results appear for exactly one cycle.
// ----------------------------------------------------------------------------
module angle_rate_quadratic_estimator_top import arqe_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic               in_action,
  input  logic [5:0]         in_point,
  input  logic signed [31:0] in_angle,
  input  logic [31:0]        in_time_now,
  output logic               out_valid,
  output logic signed [47:0] out_rate,
  output logic signed [47:0] out_accel,
  output logic               out_valid_res,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic               cfg_data
);

  st_t state_r, state_nxt;
  op_t op_r;

  logic             en_r;
  logic [1:0]       cnt_r;
  logic [POINTS-1:0] row_vld_r;

  // History memory, one row per point.
  row_t             mem [POINTS];
  row_t             rd_r;
  logic             rd_vld_r;
  logic [PT_AW-1:0] addr_r;
  logic             act_r;
  logic             inrng_r;
  logic             pt0_r;
  logic [31:0]      ang_r;
  logic [31:0]      tim_r;

  logic signed [32:0] h1_r, h2_r, hh_r;
  logic signed [32:0] da01_r, da12_r;
  logic signed [63:0] d01_r, d12_r, g_r, q3_r, q4_r;
  logic [61:0]        mg_r;
  logic [31:0]        mh2_r;
  logic [62:0]        plo_r, phi_r;
  logic [DIV_NUM_W-1:0] prod_r;
  logic signed [47:0] rate_r, accel_r;
  logic               vres_r;

  logic     accept;
  logic     in_rng;
  row_t     row;
  row_t     wr_row;
  logic     wr_en;
  logic     active;
  logic     calc_ok;
  div_req_t dreq;
  logic     ddone;
  logic signed [63:0] dquo;
  logic signed [32:0] h1, h2, hh;

  assign accept = start && !busy;
  assign in_rng = 32'(in_point) < POINTS;
  assign row    = rd_vld_r ? rd_r : '0;
  assign active = en_r && inrng_r;

  // Time differences across the fetched row and the new sample.
  assign h1 = $signed({1'b0, row.t1}) - $signed({1'b0, row.t0});
  assign h2 = $signed({1'b0, tim_r}) - $signed({1'b0, row.t1});
  assign hh = $signed({1'b0, tim_r}) - $signed({1'b0, row.t0});
  assign calc_ok = (cnt_r == 2'd3) && (h1 != 0) && (h2 != 0) && (hh != 0);

  // Write-back row: predict replaces the newest pair, update shifts back.
  always_comb begin
    wr_row = row;
    if (act_r == ACT_PREDICT) begin
      wr_row.a2 = ang_r;
      wr_row.t2 = tim_r;
    end else begin
      wr_row.a0 = row.a1;
      wr_row.t0 = row.t1;
      wr_row.a1 = row.a2;
      wr_row.t1 = row.t2;
    end
  end
  assign wr_en = (state_r == ST_EVAL) && active;

  // Divider operand selection.
  always_comb begin
    dreq       = '0;
    dreq.start = (state_r == ST_DIV);
    unique case (op_r)
      OP_D01: begin
        dreq.num = DIV_NUM_W'({abs33(da01_r), 20'b0});
        dreq.den = abs33(h1_r);
        dreq.neg = da01_r[32] ^ h1_r[32];
      end
      OP_D12: begin
        dreq.num = DIV_NUM_W'({abs33(da12_r), 20'b0});
        dreq.den = abs33(h2_r);
        dreq.neg = da12_r[32] ^ h2_r[32];
      end
      OP_RATE: begin
        dreq.num = prod_r;
        dreq.den = abs33(hh_r);
        dreq.neg = g_r[63] ^ h2_r[32] ^ hh_r[32];
      end
      OP_ACCEL: begin
        dreq.num = DIV_NUM_W'({mg_r, 21'b0});
        dreq.den = abs33(hh_r);
        dreq.neg = g_r[63] ^ hh_r[32];
      end
      default: begin
        dreq.num = '0;
      end
    endcase
  end

  arqe_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (dreq),
    .done  (ddone),
    .quo   (dquo)
  );

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:    if (start) state_nxt = ST_EVAL;
      ST_EVAL: begin
        if (active && (act_r == ACT_PREDICT) && calc_ok) begin
          state_nxt = ST_DIV;
        end else begin
          state_nxt = ST_OUT;
        end
      end
      ST_DIV:     state_nxt = ST_DIVW;
      ST_DIVW: begin
        if (ddone) begin
          unique case (op_r)
            OP_D12:   state_nxt = ST_MUL_LO;
            OP_ACCEL: state_nxt = ST_FIN;
            default:  state_nxt = ST_DIV;
          endcase
        end
      end
      ST_MUL_LO:  state_nxt = ST_MUL_HI;
      ST_MUL_HI:  state_nxt = ST_MUL_SUM;
      ST_MUL_SUM: state_nxt = ST_DIV;
      ST_FIN:     state_nxt = ST_OUT;
      ST_OUT:     state_nxt = ST_IDLE;
      default:    state_nxt = ST_IDLE;
    endcase
  end

  // Handshake outputs.
  always_comb begin
    busy      = (state_r != ST_IDLE);
    out_valid = (state_r == ST_OUT);
  end

  // The enable register only changes while no item is in flight.
  assign cfg_ready     = !busy;
  assign out_rate      = rate_r;
  assign out_accel     = accel_r;
  assign out_valid_res = vres_r;

  // Control registers: state, configuration, counter and row valid bits.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      en_r      <= 1'b0;
      cnt_r     <= 2'd0;
      row_vld_r <= '0;
    end else begin
      state_r <= state_nxt;
      if (cfg_valid && cfg_ready) begin
        en_r <= cfg_data;
      end
      if (wr_en) begin
        row_vld_r[addr_r] <= 1'b1;
        if ((act_r == ACT_UPDATE) && pt0_r && (cnt_r != 2'd3)) begin
          cnt_r <= cnt_r + 2'd1;
        end
      end
    end
  end

  // Memory: registered read at the transfer, write-back in the next cycle.
  // Only one item is in flight, so a read never overlaps a pending write.
  always_ff @(posedge clk) begin
    if (accept) begin
      rd_r <= mem[PT_AW'(in_point)];
    end
    if (wr_en) begin
      mem[addr_r] <= wr_row;
    end
  end

  // Item capture and arithmetic sequence.
  always_ff @(posedge clk) begin
    if (accept) begin
      rd_vld_r <= row_vld_r[PT_AW'(in_point)];
      addr_r   <= PT_AW'(in_point);
      act_r    <= in_action;
      inrng_r  <= in_rng;
      pt0_r    <= (in_point == 6'd0);
      ang_r    <= in_angle;
      tim_r    <= in_time_now;
    end
    unique case (state_r)
      ST_EVAL: begin
        h1_r    <= h1;
        h2_r    <= h2;
        hh_r    <= hh;
        da01_r  <= $signed({row.a1[31], row.a1}) - $signed({row.a0[31], row.a0});
        da12_r  <= $signed({ang_r[31], ang_r}) - $signed({row.a1[31], row.a1});
        op_r    <= OP_D01;
        rate_r  <= '0;
        accel_r <= '0;
        vres_r  <= 1'b0;
      end
      ST_DIVW: begin
        if (ddone) begin
          unique case (op_r)
            OP_D01: begin
              d01_r <= dquo;
              op_r  <= OP_D12;
            end
            OP_D12: begin
              d12_r <= dquo;
              g_r   <= dquo - d01_r;
              mg_r  <= abs64(dquo - d01_r);
              mh2_r <= abs33(h2_r);
              op_r  <= OP_RATE;
            end
            OP_RATE: begin
              q3_r <= dquo;
              op_r <= OP_ACCEL;
            end
            default: begin
              q4_r <= dquo;
            end
          endcase
        end
      end
      ST_MUL_LO:  plo_r  <= 63'(mg_r[30:0]) * 63'(mh2_r);
      ST_MUL_HI:  phi_r  <= 63'(mg_r[61:31]) * 63'(mh2_r);
      ST_MUL_SUM: prod_r <= DIV_NUM_W'(plo_r) + {phi_r, 31'b0};
      ST_FIN: begin
        rate_r  <= sat48(d12_r + q3_r);
        accel_r <= sat48(q4_r);
        vres_r  <= 1'b1;
      end
      default: begin
      end
    endcase
  end

  `include "angle_rate_quadratic_estimator_top_assert.svh"

  // The result strobe always returns the block to idle.
  `ARQE_ASSERT_NEXT(a_out_then_idle, clk, rst_n, out_valid, !busy)
  // A result without an estimate carries zero rate and acceleration.
  `ARQE_ASSERT_IMPL(a_zero_when_invalid, clk, rst_n, out_valid && !out_valid_res,
                    (out_rate == 48'sd0) && (out_accel == 48'sd0))
  // The update counter saturates and never leaves its top value.
  `ARQE_ASSERT_NEXT(a_cnt_sat, clk, rst_n, cnt_r == 2'd3, cnt_r == 2'd3)
  // Estimates are only computed once the history is full and enabled.
  `ARQE_ASSERT_IMPL(a_div_needs_hist, clk, rst_n, state_r == ST_DIV,
                    (cnt_r == 2'd3) && en_r)

endmodule

### rtl/arqe_div.sv
// ----------------------------------------------------------------------------
// arqe_div
// Restoring divider, four quotient bits a cycle, with rounding and clamp.
// ----------------------------------------------------------------------------
module arqe_div import arqe_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  div_req_t           req,
  output logic               done,
  output logic signed [63:0] quo
);

  logic        run_r,  run_nxt;
  logic        fin_r,  fin_nxt;
  logic        done_r, done_nxt;
  logic [3:0]  cnt_r;
  logic        big_r;
  logic        neg_r;
  logic [31:0] den_r;
  logic [32:0] rem_r;
  logic [63:0] sh_r;
  logic [63:0] q_r;
  logic signed [63:0] quo_r;

  logic [32:0] rem_step;
  logic [DIV_RADIX-1:0] qbits;
  logic [63:0] q_rnd;
  logic [63:0] q_fin;
  logic [32:0] rem_dbl;

  // Four dependent compare-and-subtract steps on a 33-bit remainder.
  always_comb begin
    logic [32:0] r;
    r = rem_r;
    for (int k = 0; k < DIV_RADIX; k++) begin
      r = {r[31:0], sh_r[63-k]};
      if (r >= {1'b0, den_r}) begin
        r = r - {1'b0, den_r};
        qbits[DIV_RADIX-1-k] = 1'b1;
      end else begin
        qbits[DIV_RADIX-1-k] = 1'b0;
      end
    end
    rem_step = r;
  end

  // Round to nearest, ties away from zero, then clamp the magnitude.
  assign rem_dbl = {rem_r[31:0], 1'b0};
  assign q_rnd   = q_r + ((rem_dbl >= {1'b0, den_r}) ? 64'd1 : 64'd0);
  assign q_fin   = (big_r || (q_rnd > QCLAMP)) ? QCLAMP : q_rnd;

  // Control flags.
  always_comb begin
    run_nxt  = run_r;
    fin_nxt  = 1'b0;
    done_nxt = 1'b0;
    if (req.start) begin
      run_nxt = 1'b1;
    end else if (run_r && (cnt_r == 4'(DIV_STEPS - 1))) begin
      run_nxt = 1'b0;
      fin_nxt = 1'b1;
    end
    if (fin_r) begin
      done_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      fin_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      run_r  <= run_nxt;
      fin_r  <= fin_nxt;
      done_r <= done_nxt;
    end
  end

  // Datapath.
  always_ff @(posedge clk) begin
    if (req.start) begin
      den_r <= req.den;
      neg_r <= req.neg;
      big_r <= req.num >= DIV_NUM_W'({req.den, 61'b0});
      rem_r <= 33'(req.num[DIV_NUM_W-1:64]);
      sh_r  <= req.num[63:0];
      q_r   <= '0;
      cnt_r <= '0;
    end else if (run_r) begin
      rem_r <= rem_step;
      sh_r  <= {sh_r[63-DIV_RADIX:0], {DIV_RADIX{1'b0}}};
      q_r   <= {q_r[63-DIV_RADIX:0], qbits};
      cnt_r <= cnt_r + 4'd1;
    end
    if (fin_r) begin
      quo_r <= neg_r ? -$signed(q_fin) : $signed(q_fin);
    end
  end

  assign done = done_r;
  assign quo  = quo_r;

endmodule

### sim/angle_rate_quadratic_estimator_top_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Angle rate quadratic estimator testbench
// Drives predict and update commands through the start/busy port and checks
// every result strobe against a predictor. The predictor keeps its own point
// histories, update counter and enable bit. The enable register is written
// between phases while the block is idle. Sender gaps vary from phase to
// phase.
// ----------------------------------------------------------------------------
module angle_rate_quadratic_estimator_top_test;
  import arqe_pkg::*;

  typedef struct packed {
    logic        action;
    logic [5:0]  point;
    logic [31:0] angle;
    logic [31:0] time_now;
  } cmd_t;

  typedef struct packed {
    logic [47:0] rate;
    logic [47:0] accel;
    logic        valid_res;
  } est_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic in_action = 1'b0;
  logic [5:0] in_point = '0;
  logic signed [31:0] in_angle = '0;
  logic [31:0] in_time_now = '0;
  logic out_valid;
  logic signed [47:0] out_rate;
  logic signed [47:0] out_accel;
  logic out_valid_res;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic cfg_data = 1'b0;

  angle_rate_quadratic_estimator_top i_dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_action(in_action), .in_point(in_point), .in_angle(in_angle),
    .in_time_now(in_time_now), .out_valid(out_valid), .out_rate(out_rate),
    .out_accel(out_accel), .out_valid_res(out_valid_res),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  // Predictor state.
  logic [31:0] hist_angle [POINTS][3];
  logic [31:0] hist_time [POINTS][3];
  int unsigned upd_count;
  logic unsteady_en;

  cmd_t cmd_queue [$];
  est_t est_queue [$];
  int errors = 0;
  int idle_pct = 0;
  longint cycles = 0;

  initial begin
    forever #5 clk = ~clk;
  end

  // Rounded a*b/c with ties away from zero, magnitude clamped to 2^60.
  function automatic logic signed [63:0] muldiv(input logic signed [63:0] a,
      input logic signed [63:0] b, input logic signed [63:0] c);
    logic [127:0] prod;
    logic [127:0] quo;
    logic [127:0] rem;
    logic [63:0] ua;
    logic [63:0] ub;
    logic [63:0] uc;
    logic [63:0] q;
    logic neg;
    ua = a[63] ? -a : a;
    ub = b[63] ? -b : b;
    uc = c[63] ? -c : c;
    neg = (a[63] ^ b[63]) ^ c[63];
    if (uc == 0) return 0;
    prod = {64'd0, ua} * {64'd0, ub};
    quo = prod / {64'd0, uc};
    rem = prod % {64'd0, uc};
    if (quo >= 128'h2000_0000_0000_0000) begin
      q = QCLAMP;
    end else begin
      q = quo[63:0];
      if (rem >= {64'd0, uc} - rem) q = q + 1;
      if (q > QCLAMP) q = QCLAMP;
    end
    return neg ? -$signed(q) : $signed(q);
  endfunction

  function automatic logic [47:0] clip48(input logic signed [63:0] v);
    if (v > MAX48) return MAX48[47:0];
    if (v < MIN48) return MIN48[47:0];
    return v[47:0];
  endfunction

  // Advance the predictor by one command and queue its expected estimate.
  task automatic predict_estimate(input cmd_t c);
    est_t e;
    logic signed [63:0] h1;
    logic signed [63:0] h2;
    logic signed [63:0] hh;
    logic signed [63:0] d01;
    logic signed [63:0] d12;
    logic signed [63:0] g;
    int p;
    e = '0;
    p = c.point;
    if (unsteady_en && p < POINTS) begin
      if (c.action == ACT_PREDICT) begin
        hist_angle[p][2] = c.angle;
        hist_time[p][2] = c.time_now;
        if (upd_count >= 3) begin
          h1 = $signed({32'd0, hist_time[p][1]}) - $signed({32'd0, hist_time[p][0]});
          h2 = $signed({32'd0, hist_time[p][2]}) - $signed({32'd0, hist_time[p][1]});
          hh = $signed({32'd0, hist_time[p][2]}) - $signed({32'd0, hist_time[p][0]});
          if (h1 != 0 && h2 != 0 && hh != 0) begin
            d01 = muldiv(64'($signed(hist_angle[p][1])) - 64'($signed(hist_angle[p][0])),
                         64'sd1 <<< 20, h1);
            d12 = muldiv(64'($signed(hist_angle[p][2])) - 64'($signed(hist_angle[p][1])),
                         64'sd1 <<< 20, h2);
            g = d12 - d01;
            e.rate = clip48(d12 + muldiv(g, h2, hh));
            e.accel = clip48(muldiv(g, 64'sd1 <<< 21, hh));
            e.valid_res = 1'b1;
          end
        end
      end else begin
        hist_angle[p][0] = hist_angle[p][1];
        hist_time[p][0] = hist_time[p][1];
        hist_angle[p][1] = hist_angle[p][2];
        hist_time[p][1] = hist_time[p][2];
        if (p == 0 && upd_count < 3) upd_count++;
      end
    end
    est_queue.push_back(e);
  endtask

  // Driver: present queued commands, keep start high across back-to-back items.
  always @(posedge clk) begin
    if (rst_n) begin
      if (start && !busy) begin
        predict_estimate({in_action, in_point, in_angle, in_time_now});
      end
      if (!(start && busy)) begin
        if (cmd_queue.size() > 0 && $urandom_range(99) >= idle_pct) begin
          cmd_t c;
          c = cmd_queue.pop_front();
          start <= 1'b1;
          in_action <= c.action;
          in_point <= c.point;
          in_angle <= c.angle;
          in_time_now <= c.time_now;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // Monitor: compare each result strobe with the oldest expectation.
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (est_queue.size() == 0) begin
        $display("%0t: unexpected result rate=%h accel=%h valid_res=%b", $time,
                 out_rate, out_accel, out_valid_res);
        errors++;
      end else begin
        est_t e;
        e = est_queue.pop_front();
        if (out_rate !== e.rate) begin
          $display("%0t: rate expected %h actual %h", $time, e.rate, out_rate);
          errors++;
        end
        if (out_accel !== e.accel) begin
          $display("%0t: accel expected %h actual %h", $time, e.accel, out_accel);
          errors++;
        end
        if (out_valid_res !== e.valid_res) begin
          $display("%0t: valid_res expected %b actual %b", $time, e.valid_res,
                   out_valid_res);
          errors++;
        end
      end
    end
  end

  // Cycle limit.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 600000) begin
      $display("angle_rate_quadratic_estimator_top_test: FAIL");
      $finish;
    end
  end

  function automatic logic [31:0] rand_angle();
    case ($urandom_range(5))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return $urandom_range(4095) - 2048;
      default: return $urandom;
    endcase
  endfunction

  task automatic wait_drained();
    while (cmd_queue.size() > 0 || start || busy || est_queue.size() > 0)
      @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic write_enable(input logic value);
    cfg_valid <= 1'b1;
    cfg_data <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    unsteady_en = value;
    cfg_valid <= 1'b0;
  endtask

  // Well-formed fill of three pairs at a point, with random time steps.
  task automatic push_sequence(input int p, inout logic [31:0] t);
    cmd_t c;
    for (int k = 0; k < 3; k++) begin
      t = t + (($urandom_range(9) == 0) ? 0 : $urandom_range(1 << $urandom_range(24)));
      c = '{ACT_PREDICT, 6'(p), rand_angle(), t};
      cmd_queue.push_back(c);
      if (k < 2 || $urandom_range(1)) begin
        c.action = ACT_UPDATE;
        cmd_queue.push_back(c);
        if ($urandom_range(3) == 0) cmd_queue.push_back('{ACT_UPDATE, 6'd0, 0, 0});
      end
    end
  endtask

  initial begin
    logic [31:0] t;
    cmd_t c;
    for (int p = 0; p < POINTS; p++)
      for (int k = 0; k < 3; k++) begin
        hist_angle[p][k] = '0;
        hist_time[p][k] = '0;
      end
    upd_count = 0;
    unsteady_en = 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Steady mode: every command returns zeros.
    cmd_queue.push_back('{ACT_UPDATE, 6'd0, 32'h7fff_ffff, 32'hffff_ffff});
    cmd_queue.push_back('{ACT_PREDICT, 6'd63, 32'h8000_0000, 32'd0});
    wait_drained();

    // Directed: counter fill, extremes, coincident times, saturation.
    write_enable(1'b1);
    cmd_queue.push_back('{ACT_PREDICT, 6'd0, 32'd100, 32'd10});
    cmd_queue.push_back('{ACT_UPDATE, 6'd0, 0, 0});
    cmd_queue.push_back('{ACT_PREDICT, 6'd0, 32'd400, 32'd20});
    cmd_queue.push_back('{ACT_UPDATE, 6'd0, 0, 0});
    cmd_queue.push_back('{ACT_PREDICT, 6'd0, 32'd900, 32'd30});
    cmd_queue.push_back('{ACT_UPDATE, 6'd0, 0, 0});
    cmd_queue.push_back('{ACT_PREDICT, 6'd0, 32'd1600, 32'd40});
    cmd_queue.push_back('{ACT_PREDICT, 6'd0, 32'd1600, 32'd30});
    cmd_queue.push_back('{ACT_PREDICT, 6'd0, 32'h7fff_ffff, 32'd31});
    cmd_queue.push_back('{ACT_UPDATE, 6'd0, 0, 0});
    cmd_queue.push_back('{ACT_PREDICT, 6'd0, 32'h8000_0000, 32'd32});
    cmd_queue.push_back('{ACT_PREDICT, 6'd0, 32'h8000_0000, 32'hffff_ffff});
    cmd_queue.push_back('{ACT_UPDATE, 6'd0, 0, 0});
    cmd_queue.push_back('{ACT_PREDICT, 6'd0, 32'h7fff_ffff, 32'd0});
    cmd_queue.push_back('{ACT_PREDICT, 6'd63, 32'h1234_5678, 32'd5});
    cmd_queue.push_back('{ACT_PREDICT, 6'd0, 32'h7fff_ffff, 32'd1});
    cmd_queue.push_back('{ACT_UPDATE, 6'd63, 0, 0});
    cmd_queue.push_back('{ACT_PREDICT, 6'd63, 32'h8000_0000, 32'h8000_0000});
    wait_drained();

    // Random phases with varying sender gaps and enable settings.
    for (int ph = 0; ph < 6; ph++) begin
      idle_pct = (ph % 3 == 0) ? 0 : ((ph % 3 == 1) ? 65 : 14);
      if (ph == 4) write_enable(1'b0);
      if (ph == 5) write_enable(1'b1);
      t = $urandom;
      for (int n = 0; n < 40; n++) begin
        if ($urandom_range(4) == 0) begin
          c.action = 1'($urandom_range(1));
          c.point = 6'($urandom);
          c.angle = 32'($urandom);
          c.time_now = 32'($urandom);
          cmd_queue.push_back(c);
        end else begin
          push_sequence(($urandom_range(3) == 0) ? $urandom_range(63) : $urandom_range(3), t);
        end
      end
      wait_drained();
    end

    if (errors == 0) begin
      $display("angle_rate_quadratic_estimator_top_test: PASS");
    end else begin
      $display("angle_rate_quadratic_estimator_top_test: FAIL");
    end
    $finish;
  end

endmodule
